// ===== src/wildcard_glob_matcher_core_defines.svh =====
// Assertion macros shared by the checker
`ifndef WILDCARD_GLOB_MATCHER_CORE_DEFINES_SVH
`define WILDCARD_GLOB_MATCHER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define WGM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wgm assertion failed");

// Next-cycle implication, checked outside reset
`define WGM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wgm assertion failed");

`endif

// ===== src/wgm_pkg.sv =====
`timescale 1ns / 1ps
package wgm_pkg;

  localparam int MAX_PATTERN = 64;
  localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
  localparam int IDX_W       = $clog2(MAX_PATTERN);
  localparam int SCAN_LEVELS = $clog2(MAX_PATTERN + 1);

  localparam logic [7:0] CH_QUESTION = 8'h3F;
  localparam logic [7:0] CH_STAR     = 8'h2A;
  localparam logic [7:0] CH_DOT      = 8'h2E;
  localparam logic [7:0] CH_LOW_A    = 8'h61;
  localparam logic [7:0] CH_LOW_Z    = 8'h7A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  localparam logic [1:0] OP_PATTERN = 2'd0;
  localparam logic [1:0] OP_CAND    = 2'd1;
  localparam logic [1:0] OP_END     = 2'd2;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] ch;
    logic       first;
  } in_t;

  typedef struct packed {
    logic matched;
    logic overflow;
  } out_t;

  typedef struct packed {
    logic       en;
    logic       first;
    logic [7:0] ch;
  } pat_wr_t;

  typedef struct packed {
    logic [MAX_PATTERN-1:0] star;
    logic [MAX_PATTERN-1:0] fits;
    logic [LEN_W-1:0]       len;
    logic                   ovf;
  } pat_stat_t;

endpackage

// ===== src/wildcard_glob_matcher_core.sv =====
`timescale 1ns / 1ps
// A request is registered in in_r, then processed from there; a match result is registered
// into out_r and shown on out_valid when its end-of-candidate request advances from in_r.
// Throughput: one request per cycle; the reach vector update feeds reach_r back through closed.
// Only an end request waiting behind a stalled result holds the input side.
// Reset (synchronous, rst_n low): empty pattern, overflow clear, exact byte compare.
module wildcard_glob_matcher_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  wgm_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output wgm_pkg::out_t out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic          cfg_data
);

  localparam int M = wgm_pkg::MAX_PATTERN;

  wgm_pkg::in_t       in_r;
  logic               in_v_r;
  logic               case_r;
  logic [M:0]         reach_r, reach_nxt, closed;
  logic               out_v_r, out_v_nxt;
  wgm_pkg::out_t      out_r;
  logic               is_end, out_free, adv;
  wgm_pkg::pat_wr_t   pat_wr;
  wgm_pkg::pat_stat_t stat;

  // Prefix scan: a reachable star lets the position after it be reached,
  // carried through any run of stars in log depth.
  function automatic logic [M:0] close_stars(input logic [M:0] v, input logic [M-1:0] star);
    logic [M:0] g, a, gn, an;
    g = v;
    a = {star, 1'b0};
    for (int l = 0; l < wgm_pkg::SCAN_LEVELS; l++) begin
      gn = g;
      an = a;
      for (int j = 0; j <= M; j++) begin
        if (j >= (1 << l)) begin
          gn[j] = g[j] | (a[j] & g[j - (1 << l)]);
          an[j] = a[j] & a[j - (1 << l)];
        end
      end
      g = gn;
      a = an;
    end
    return g;
  endfunction

  assign is_end   = in_r.op == wgm_pkg::OP_END;
  assign out_free = !out_v_r || !out_stall;
  assign adv      = in_v_r && (!is_end || out_free);
  assign in_stall = in_v_r && !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (!in_stall) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_r <= in_data;
    end
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      case_r <= 1'b1;
    end else if (cfg_valid) begin
      case_r <= cfg_data;
    end
  end

  assign pat_wr.en    = adv && (in_r.op == wgm_pkg::OP_PATTERN);
  assign pat_wr.first = in_r.first;
  assign pat_wr.ch    = in_r.ch;

  wgm_pattern u_pattern (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (pat_wr),
    .cand_ch   (in_r.ch),
    .case_sens (case_r),
    .stat      (stat)
  );

  assign closed = close_stars(reach_r, stat.star);

  always_comb begin
    case (in_r.op)
      wgm_pkg::OP_PATTERN: reach_nxt = (M + 1)'(1);
      // stars hold their own position, fitting bytes advance one
      wgm_pkg::OP_CAND:    reach_nxt = {1'b0, closed[M-1:0] & stat.star}
                                     | {closed[M-1:0] & stat.fits, 1'b0};
      wgm_pkg::OP_END:     reach_nxt = (M + 1)'(1);
      default:             reach_nxt = reach_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reach_r <= (M + 1)'(1);
    end else if (adv) begin
      reach_r <= reach_nxt;
    end
  end

  always_comb begin
    if (adv && is_end) begin
      out_v_nxt = 1'b1;
    end else if (!out_stall) begin
      out_v_nxt = 1'b0;
    end else begin
      out_v_nxt = out_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && is_end) begin
      out_r.matched  <= closed[stat.len] && !stat.ovf;
      out_r.overflow <= stat.ovf;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

// ===== src/wgm_pattern.sv =====
`timescale 1ns / 1ps
module wgm_pattern (
  input  logic               clk,
  input  logic               rst_n,
  input  wgm_pkg::pat_wr_t   wr,
  input  logic [7:0]         cand_ch,
  input  logic               case_sens,
  output wgm_pkg::pat_stat_t stat
);

  logic [7:0]              store_r [wgm_pkg::MAX_PATTERN];
  logic [wgm_pkg::LEN_W-1:0] len_r, len_nxt, len_eff;
  logic                    ovf_r, ovf_nxt;
  logic                    room;
  logic [7:0]              cand_f;

  function automatic logic [7:0] fold(input logic [7:0] c, input logic cs);
    if (!cs && c >= wgm_pkg::CH_LOW_A && c <= wgm_pkg::CH_LOW_Z) begin
      return c - wgm_pkg::CASE_OFFSET;
    end
    return c;
  endfunction

  assign len_eff = wr.first ? '0 : len_r;
  assign room    = len_eff < wgm_pkg::LEN_W'(wgm_pkg::MAX_PATTERN);
  assign len_nxt = room ? len_eff + wgm_pkg::LEN_W'(1) : len_eff;
  // a new pattern clears the flag first, then a byte with no room sets it
  assign ovf_nxt = (wr.first ? 1'b0 : ovf_r) | !room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      ovf_r <= 1'b0;
    end else if (wr.en) begin
      len_r <= len_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && room) begin
      store_r[len_eff[wgm_pkg::IDX_W-1:0]] <= wr.ch;
    end
  end

  assign cand_f = fold(cand_ch, case_sens);

  always_comb begin
    stat.len = len_r;
    stat.ovf = ovf_r;
    for (int i = 0; i < wgm_pkg::MAX_PATTERN; i++) begin
      if (wgm_pkg::LEN_W'(i) < len_r) begin
        stat.star[i] = store_r[i] == wgm_pkg::CH_STAR;
        if (store_r[i] == wgm_pkg::CH_STAR) begin
          stat.fits[i] = 1'b0;
        end else if (store_r[i] == wgm_pkg::CH_QUESTION) begin
          stat.fits[i] = cand_ch != wgm_pkg::CH_DOT;
        end else begin
          stat.fits[i] = fold(store_r[i], case_sens) == cand_f;
        end
      end else begin
        stat.star[i] = 1'b0;
        stat.fits[i] = 1'b0;
      end
    end
  end

endmodule

// ===== src/wgm_checker.sv =====
`timescale 1ns / 1ps
`include "wildcard_glob_matcher_core_defines.svh"
module wgm_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_stall,
  input logic          out_valid,
  input logic          out_stall,
  input wgm_pkg::out_t out_data
);

  // hold a stalled result
  `WGM_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
  // an overflowed pattern never matches
  `WGM_ASSERT_IMP(a_ovf_nomatch, out_valid && out_data.overflow, !out_data.matched)
  // the input side only stalls behind a stalled result
  `WGM_ASSERT_IMP(a_stall_cause, in_stall, out_valid && out_stall)
  // no result straight out of reset
  `WGM_ASSERT_IMP(a_reset_idle, !$past(rst_n), !out_valid)

endmodule

bind wildcard_glob_matcher_core wgm_checker u_chk (.*);
